@@ hw/rtl/rcc_pkg.sv @@
// Shared types, constants and helpers for the river channel carve block.
`timescale 1ns / 1ps

package rcc_pkg;

    localparam int MAP_WIDTH  = 64;
    localparam int MAP_DEPTH  = 64;
    localparam int MAX_RADIUS = 8;

    localparam int ADDR_W  = $clog2(MAP_WIDTH * MAP_DEPTH);
    localparam int COORD_W = 6;
    localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
    localparam int NX_W    = 12;
    localparam int D2_W    = 2 * RAD_W + 3;
    localparam int DD_W    = D2_W + 32;
    localparam int DIV_W   = 34;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_CARVE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] CFG_CELL_SIZE     = 2'd0;
    localparam logic [1:0] CFG_CHANNEL_DEPTH = 2'd1;
    localparam logic [1:0] CFG_BED_FLATNESS  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_RD,
        S_CUT,
        S_CRD,
        S_SURF,
        S_BED,
        S_RAD,
        S_NB,
        S_NRD,
        S_NCMP,
        S_ROOT,
        S_DIVI,
        S_DIV,
        S_SQ,
        S_SM,
        S_BK0,
        S_BK1,
        S_BK2,
        S_BK3,
        S_FIN
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v > 34'sh0_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            res = -32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [NX_W-1:0] x,
                                                  input logic [NX_W-1:0] z);
        return ADDR_W'(int'(z) * MAP_WIDTH + int'(x));
    endfunction

endpackage

@@ hw/rtl/river_channel_carve.sv @@
// River channel carve: height map store with load, carve and read operations.
`timescale 1ns / 1ps

// Usage:
//   Input channel i_valid/o_ready carries one operation item: op, cell
//   coordinates, a height to load and the segment width and depth.
//   Output channel o_valid/i_ready returns one result item per input item:
//   the stored height for a read (else zero) and a done flag.
//   Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data;
//   the user must do so only while the block is idle, which it does not enforce.
// Timing:
//   One item is worked on at a time; o_ready is high only when idle.
//   Load and read: the item goes through S_LOAD or S_RD, then S_FIN, which
//   registers the result once the output register is free. A carve runs the
//   setup states S_CUT, S_CRD, S_SURF, S_BED and S_RAD (which finds R, the
//   saturated radius), then visits (2R+1)^2 neighbors: the center or an off-map
//   cell is skipped, a channel or outer cell is read and compared, and a bank
//   cell also takes a 32-step square root, 17-step divider, squaring, smoothstep
//   and, if it lies above the surface, two partial-product multiplies.
// Reset clears control state and restores register defaults; the height map
//   holds no defined value until loaded.
// Stall: a finished result waits in the output register; the next item is
//   accepted meanwhile, and a new result waits until the old one is taken.
module river_channel_carve
    import rcc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_op,
    input  logic [COORD_W-1:0]        i_cell_x,
    input  logic [COORD_W-1:0]        i_cell_z,
    input  logic signed [31:0]        i_height_in,
    input  logic [15:0]               i_river_width,
    input  logic [15:0]               i_river_depth,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [31:0]        o_height_out,
    output logic                      o_op_done,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [15:0]               i_cfg_data
);

    t_state r_state, n_state;

    logic [15:0] r_cell_size, r_chan_depth, r_bed_flat;

    logic [1:0]          r_op;
    logic [COORD_W-1:0]  r_cx, r_cz;
    logic signed [31:0]  r_hin;
    logic [15:0]         r_w, r_dep;
    logic                r_inside;

    logic [20:0]         r_cut, r_bfp;
    logic [15:0]         r_c1;
    logic [31:0]         r_c2, r_w2;
    logic [35:0]         r_w9;
    logic signed [31:0]  r_hc, r_surf, r_bed;
    logic [RAD_W-1:0]    r_rad;
    logic [17:0]         r_acc;
    logic signed [RAD_W:0] r_dx, r_dz;
    logic [D2_W-1:0]     r_d2;
    logic signed [31:0]  r_h;
    logic [DD_W-1:0]     r_dd;
    logic [63:0]         r_rv, r_rr, r_rb;
    logic [DIV_W-1:0]    r_rem;
    logic [16:0]         r_q;
    logic [4:0]          r_di;
    logic [16:0]         r_tt, r_s;
    logic [32:0]         r_diff;
    logic [33:0]         r_plo;
    logic [32:0]         r_phi;

    logic                r_ovalid, r_odone;
    logic signed [31:0]  r_hout;

    logic [31:0]         mem [MAP_WIDTH*MAP_DEPTH];
    logic [31:0]         r_mem_q;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr, c_addr, nb_addr;
    logic [31:0]         mem_wdata;
    logic                adv;

    logic                accept, out_free, rad_more, nb_skip, nb_in, nb_last;
    logic                is_chan, is_bank, bank_lt;
    logic signed [RAD_W:0]  rad_s;
    logic signed [NX_W-1:0] nb_nx, nb_nz;
    logic [DD_W+1:0]     dd4;
    logic [RAD_W:0]      adx, adz;
    logic [63:0]         root_sum;
    logic [DIV_W-1:0]    div_d;
    logic [16:0]         t_cl;
    logic [50:0]         bk_prod;
    logic signed [35:0]  bank;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign out_free = !r_ovalid || i_ready;
    assign o_valid      = r_ovalid;
    assign o_height_out = r_hout;
    assign o_op_done    = r_odone;

    assign rad_s   = $signed({1'b0, r_rad});
    assign rad_more = (r_rad < RAD_W'(MAX_RADIUS)) && (r_acc < {2'b00, r_w});
    assign nb_nx   = NX_W'($signed({1'b0, r_cx})) + NX_W'(r_dx);
    assign nb_nz   = NX_W'($signed({1'b0, r_cz})) + NX_W'(r_dz);
    assign nb_in   = (nb_nx >= 0) && (nb_nx < $signed(NX_W'(MAP_WIDTH)))
                  && (nb_nz >= 0) && (nb_nz < $signed(NX_W'(MAP_DEPTH)));
    assign nb_skip = !nb_in || (r_dx == 0 && r_dz == 0);
    assign nb_last = (r_dx == rad_s) && (r_dz == rad_s);
    assign c_addr  = addr_of(NX_W'(r_cx), NX_W'(r_cz));
    assign nb_addr = addr_of(nb_nx, nb_nz);
    assign adx     = r_dx[RAD_W] ? $unsigned(-r_dx) : $unsigned(r_dx);
    assign adz     = r_dz[RAD_W] ? $unsigned(-r_dz) : $unsigned(r_dz);
    assign dd4     = {r_dd, 2'b00};
    assign is_chan = dd4 <= (DD_W+2)'(r_w2);
    assign is_bank = (dd4 <= (DD_W+2)'(r_w9)) && (r_w != 16'd0);
    assign root_sum = r_rr + r_rb;
    assign div_d   = DIV_W'(r_w) << r_di;
    assign t_cl    = (r_q > 17'd65536) ? 17'd65536 : r_q;
    assign bk_prod = {r_phi, 17'b0} + 51'(r_plo);
    assign bank    = 36'(r_surf) + $signed({1'b0, bk_prod[50:16]});
    assign bank_lt = bank < 36'(r_h);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_op)
                        OP_LOAD:  n_state = S_LOAD;
                        OP_READ:  n_state = S_RD;
                        OP_CARVE: n_state = (32'(i_cell_x) < MAP_WIDTH
                                          && 32'(i_cell_z) < MAP_DEPTH) ? S_CUT : S_FIN;
                        default:  n_state = S_FIN;
                    endcase
                end
            end
            S_LOAD: n_state = S_FIN;
            S_RD:   n_state = S_FIN;
            S_CUT:  n_state = S_CRD;
            S_CRD:  n_state = S_SURF;
            S_SURF: n_state = S_BED;
            S_BED:  n_state = S_RAD;
            S_RAD:  n_state = rad_more ? S_RAD : S_NB;
            S_NB:   n_state = nb_skip ? (nb_last ? S_FIN : S_NB) : S_NRD;
            S_NRD:  n_state = S_NCMP;
            S_NCMP: begin
                if (!is_chan && is_bank) begin
                    n_state = S_ROOT;
                end else begin
                    n_state = nb_last ? S_FIN : S_NB;
                end
            end
            S_ROOT: n_state = (r_rb == 64'd1) ? S_DIVI : S_ROOT;
            S_DIVI: n_state = S_DIV;
            S_DIV:  n_state = (r_di == 5'd0) ? S_SQ : S_DIV;
            S_SQ:   n_state = S_SM;
            S_SM:   n_state = S_BK0;
            S_BK0:  n_state = (r_h > r_surf) ? S_BK1 : (nb_last ? S_FIN : S_NB);
            S_BK1:  n_state = S_BK2;
            S_BK2:  n_state = S_BK3;
            S_BK3:  n_state = nb_last ? S_FIN : S_NB;
            S_FIN:  n_state = out_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = c_addr;
        mem_wdata = r_hin;
        mem_raddr = c_addr;
        adv       = 1'b0;
        case (r_state)
            S_LOAD: mem_we = r_inside;
            S_BED: begin
                mem_we    = r_surf < r_hc;
                mem_wdata = r_surf;
            end
            S_NB: begin
                mem_raddr = nb_addr;
                adv       = nb_skip;
            end
            S_NCMP: begin
                mem_waddr = nb_addr;
                mem_wdata = r_bed;
                mem_we    = is_chan && (r_bed < r_h);
                adv       = is_chan || !is_bank;
            end
            S_BK0: adv = !(r_h > r_surf);
            S_BK3: begin
                mem_waddr = nb_addr;
                mem_wdata = bank[31:0];
                mem_we    = bank_lt;
                adv       = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cell_size  <= 16'd256;
            r_chan_depth <= 16'd4096;
            r_bed_flat   <= 16'd39322;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CELL_SIZE:     r_cell_size  <= i_cfg_data;
                    CFG_CHANNEL_DEPTH: r_chan_depth <= i_cfg_data;
                    CFG_BED_FLATNESS:  r_bed_flat   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_op;
            r_cx     <= i_cell_x;
            r_cz     <= i_cell_z;
            r_hin    <= i_height_in;
            r_w      <= i_river_width;
            r_dep    <= i_river_depth;
            r_inside <= (32'(i_cell_x) < MAP_WIDTH) && (32'(i_cell_z) < MAP_DEPTH);
        end
        if (adv) begin
            if (r_dx == rad_s) begin
                r_dx <= -rad_s;
                r_dz <= r_dz + 1'b1;
            end else begin
                r_dx <= r_dx + 1'b1;
            end
        end
        case (r_state)
            S_CUT: begin
                r_cut <= 21'((33'(r_dep) * 33'(r_chan_depth) + 33'd2048) >> 12);
                r_c1  <= (r_cell_size == 16'd0) ? 16'd1 : r_cell_size;
                r_w2  <= 32'(r_w) * 32'(r_w);
            end
            S_CRD: begin
                r_bfp <= 21'((38'(r_cut) * 38'(r_bed_flat) + 38'd32768) >> 16);
                r_c2  <= 32'(r_c1) * 32'(r_c1);
                r_w9  <= {r_w2, 3'b000} + 36'(r_w2);
                r_hc  <= r_mem_q;
            end
            S_SURF: r_surf <= sat32(34'(r_hc) - 34'(r_cut));
            S_BED: begin
                r_bed <= sat32(34'(r_surf) - 34'(r_bfp));
                r_acc <= 18'd0;
                r_rad <= '0;
            end
            S_RAD: begin
                if (rad_more) begin
                    r_acc <= r_acc + {1'b0, r_c1, 1'b0};
                    r_rad <= r_rad + 1'b1;
                end else begin
                    r_dx <= -rad_s;
                    r_dz <= -rad_s;
                end
            end
            S_NB: r_d2 <= D2_W'(adx) * D2_W'(adx) + D2_W'(adz) * D2_W'(adz);
            S_NRD: begin
                r_h  <= r_mem_q;
                r_dd <= DD_W'(r_d2) * DD_W'(r_c2);
            end
            S_NCMP: begin
                r_rv <= 64'(r_dd) << 16;
                r_rr <= 64'd0;
                r_rb <= 64'd1 << 62;
            end
            S_ROOT: begin
                if (r_rv >= root_sum) begin
                    r_rv <= r_rv - root_sum;
                    r_rr <= (r_rr >> 1) + r_rb;
                end else begin
                    r_rr <= r_rr >> 1;
                end
                r_rb <= r_rb >> 2;
            end
            S_DIVI: begin
                r_rem <= (r_rr[DIV_W-1:0] - (DIV_W'(r_w) << 7)) << 8;
                r_q   <= 17'd0;
                r_di  <= 5'd16;
            end
            S_DIV: begin
                if (r_rem >= div_d) begin
                    r_rem <= r_rem - div_d;
                    r_q   <= {r_q[15:0], 1'b1};
                end else begin
                    r_q   <= {r_q[15:0], 1'b0};
                end
                r_di <= r_di - 1'b1;
            end
            S_SQ: r_tt <= 17'((34'(t_cl) * 34'(t_cl)) >> 16);
            S_SM: r_s  <= 17'((35'(r_tt) * 35'(18'd196608 - {t_cl, 1'b0})) >> 16);
            S_BK0: r_diff <= 33'(34'(r_h) - 34'(r_surf));
            S_BK1: r_plo  <= 34'(r_diff[16:0]) * 34'(r_s);
            S_BK2: r_phi  <= 33'(r_diff[32:17]) * 33'(r_s);
            S_FIN: begin
                if (out_free) begin
                    r_hout  <= (r_op == OP_READ && r_inside) ? r_mem_q : 32'sd0;
                    r_odone <= (r_op == OP_LOAD) || (r_op == OP_CARVE) || (r_op == OP_READ);
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != S_IDLE && r_state != S_FIN))
        else $error("store written outside an operation");

    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> (o_valid && r_state == S_IDLE))
        else $error("finished item not presented");

    a_root_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> $onehot(r_rb))
        else $error("root bit not one-hot");
`endif

endmodule
